// File: hdl/lcc_pkg.sv
// Package: shared types, codes and constants of the login credential checker.
`default_nettype none

package lcc_pkg;

  localparam int unsigned BUF_LIMIT_DEF = 128;
  localparam int unsigned KEY_BYTES_DEF = 8;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned KLEN_W   = 4;
  localparam int unsigned TICK_W   = 6;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned EV_W     = 3;

  localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

  localparam logic [KEY_W-1:0]  USER_KEY_RST     = '0;
  localparam logic [KEY_W-1:0]  PASS_KEY_RST     = '0;
  localparam logic [KLEN_W-1:0] USER_KEY_LEN_RST = 4'd8;
  localparam logic [KLEN_W-1:0] PASS_KEY_LEN_RST = 4'd8;
  localparam logic [TICK_W-1:0] TIMEOUT_RST      = 6'd30;

  typedef enum logic [EV_W-1:0] {
    EV_ECHO     = 3'd0,
    EV_ASK_PASS = 3'd1,
    EV_GRANTED  = 3'd2,
    EV_DENIED   = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_USER_KEY     = 3'd0,
    CFG_PASS_KEY     = 3'd1,
    CFG_USER_KEY_LEN = 3'd2,
    CFG_PASS_KEY_LEN = 3'd3,
    CFG_TIMEOUT      = 3'd4
  } cfg_idx_e;

  // Configuration as seen by the checking logic
  typedef struct packed {
    logic [KEY_W-1:0]  user_key;
    logic [KEY_W-1:0]  pass_key;
    logic [KLEN_W-1:0] user_key_len;
    logic [KLEN_W-1:0] pass_key_len;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  // One step's outcome, core to result register
  typedef struct packed {
    logic              has_res;
    event_e            ev;
    logic [CHAR_W-1:0] chr;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/lcc_if.sv
// Interfaces: item, result and configuration channels.
`default_nettype none

interface lcc_in_if;
  import lcc_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_in;
  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface lcc_out_if;
  import lcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [CHAR_W-1:0] char_out;
  modport source (output valid, output event_res, output char_out, input ready);
  modport sink   (input valid, input event_res, input char_out, output ready);
endinterface

interface lcc_cfg_if;
  import lcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [KEY_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/lcc_cfg_regs.sv
// Configuration register file of the login credential checker.
`default_nettype none

module lcc_cfg_regs
  import lcc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcc_cfg_if.sink    cfg_chan_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_key      <= USER_KEY_RST;
      cfg_q.pass_key      <= PASS_KEY_RST;
      cfg_q.user_key_len  <= USER_KEY_LEN_RST;
      cfg_q.pass_key_len  <= PASS_KEY_LEN_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_chan_i.valid) begin
      unique case (cfg_chan_i.index)
        CFG_USER_KEY:     cfg_q.user_key      <= cfg_chan_i.data;
        CFG_PASS_KEY:     cfg_q.pass_key      <= cfg_chan_i.data;
        CFG_USER_KEY_LEN: cfg_q.user_key_len  <= cfg_chan_i.data[KLEN_W-1:0];
        CFG_PASS_KEY_LEN: cfg_q.pass_key_len  <= cfg_chan_i.data[KLEN_W-1:0];
        CFG_TIMEOUT:      cfg_q.timeout_ticks <= cfg_chan_i.data[TICK_W-1:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/lcc_core.sv
// Login state registers and the single-pass step logic.
`default_nettype none

module lcc_core
  import lcc_pkg::*;
#(
  parameter int unsigned BUF_LIMIT = BUF_LIMIT_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              mode_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output res_t                   res_o
);

  localparam int unsigned CNT_W = $clog2(BUF_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUF_LIMIT);

  logic              pw_phase_q, pw_phase_d;
  logic [CNT_W-1:0]  user_cnt_q, user_cnt_d;
  logic [CNT_W-1:0]  pass_cnt_q, pass_cnt_d;
  logic              user_ok_q, user_ok_d;
  logic              pass_ok_q, pass_ok_d;
  logic              tmr_run_q, tmr_run_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  // True when char sits at position pos of the key; positions past the key never match
  function automatic logic key_hit(logic [KEY_W-1:0] key, logic [CNT_W-1:0] pos,
                                   logic [CHAR_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (pos == CNT_W'(i) && key[CHAR_W*i +: CHAR_W] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  always_comb begin
    pw_phase_d  = pw_phase_q;
    user_cnt_d  = user_cnt_q;
    pass_cnt_d  = pass_cnt_q;
    user_ok_d   = user_ok_q;
    pass_ok_d   = pass_ok_q;
    tmr_run_d   = tmr_run_q;
    tick_d      = tick_q;
    res_o.has_res = 1'b0;
    res_o.ev      = EV_ECHO;
    res_o.chr     = '0;

    if (mode_i) begin
      // timer tick
      if (tmr_run_q) begin
        if (tick_q >= cfg_i.timeout_ticks) begin
          pw_phase_d = 1'b0;
          user_cnt_d = '0;
          pass_cnt_d = '0;
          user_ok_d  = 1'b1;
          pass_ok_d  = 1'b1;
          tmr_run_d  = 1'b0;
          tick_d     = '0;
          res_o.has_res = 1'b1;
          res_o.ev      = EV_TIMEOUT;
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
    end else if (!pw_phase_q) begin
      if (char_i == CHAR_CR) begin
        pw_phase_d = 1'b1;
        pass_cnt_d = '0;
        pass_ok_d  = 1'b1;
        tmr_run_d  = 1'b1;
        tick_d     = '0;
        res_o.has_res = 1'b1;
        res_o.ev      = EV_ASK_PASS;
      end else if (user_cnt_q < CNT_LIMIT) begin
        if (!key_hit(cfg_i.user_key, user_cnt_q, char_i)) user_ok_d = 1'b0;
        user_cnt_d = user_cnt_q + 1'b1;
        res_o.has_res = 1'b1;
        res_o.ev      = EV_ECHO;
        res_o.chr     = char_i;
      end
    end else begin
      if (char_i == CHAR_CR) begin
        pw_phase_d = 1'b0;
        user_cnt_d = '0;
        pass_cnt_d = '0;
        user_ok_d  = 1'b1;
        pass_ok_d  = 1'b1;
        tmr_run_d  = 1'b0;
        tick_d     = '0;
        res_o.has_res = 1'b1;
        if (user_cnt_q == CNT_W'(cfg_i.user_key_len) &&
            pass_cnt_q == CNT_W'(cfg_i.pass_key_len) && user_ok_q && pass_ok_q) begin
          res_o.ev = EV_GRANTED;
        end else begin
          res_o.ev = EV_DENIED;
        end
      end else if (pass_cnt_q < CNT_LIMIT) begin
        if (!key_hit(cfg_i.pass_key, pass_cnt_q, char_i)) pass_ok_d = 1'b0;
        pass_cnt_d = pass_cnt_q + 1'b1;
        res_o.has_res = 1'b1;
        res_o.ev      = EV_ECHO;
        res_o.chr     = CHAR_STAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_phase_q <= 1'b0;
      user_cnt_q <= '0;
      pass_cnt_q <= '0;
      user_ok_q  <= 1'b1;
      pass_ok_q  <= 1'b1;
      tmr_run_q  <= 1'b0;
      tick_q     <= '0;
    end else if (step_i) begin
      pw_phase_q <= pw_phase_d;
      user_cnt_q <= user_cnt_d;
      pass_cnt_q <= pass_cnt_d;
      user_ok_q  <= user_ok_d;
      pass_ok_q  <= pass_ok_d;
      tmr_run_q  <= tmr_run_d;
      tick_q     <= tick_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lcc_result_reg.sv
// Output register holding one result until the sink takes it.
`default_nettype none

module lcc_result_reg
  import lcc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire res_t  res_i,
  lcc_out_if.source  res_chan_o
);

  logic              valid_q;
  event_e            ev_q;
  logic [CHAR_W-1:0] chr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_chan_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q  <= res_i.ev;
      chr_q <= res_i.chr;
    end
  end

  assign res_chan_o.valid     = valid_q;
  assign res_chan_o.event_res = ev_q;
  assign res_chan_o.char_out  = chr_q;

endmodule

`default_nettype wire

// File: hdl/login_credential_checker.sv
// Top level of the login credential checker: input register, core, result register.
`default_nettype none

//  channel      | dir | payload                        | notes
//  -------------+-----+--------------------------------+-------------------------------
//  in_chan_i    | in  | mode, char_in                  | char or timer tick
//  res_chan_o   | out | event_res, char_out            | zero or one result per item
//  cfg_chan_i   | in  | index (3b), data (64b)         | always ready, write when idle
//
// An accepted item waits in the input register and is stepped through the core once the
// output slot is free; its result is registered in the output register at the end of that
// step. One item per cycle sustained while the output is not stalled.
// Reset returns the login to the username phase, timer stopped, keys cleared and
// key lengths 8, timeout 30 ticks.
// A stalled output holds the item in the input register; input ready then follows
// the output side combinationally, so a freed slot is refilled in the same cycle.
module login_credential_checker
  import lcc_pkg::*;
#(
  parameter int unsigned BUF_LIMIT = BUF_LIMIT_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcc_in_if.sink     in_chan_i,
  lcc_out_if.source  res_chan_o,
  lcc_cfg_if.sink    cfg_chan_i
);

  cfg_t              cfg;
  res_t              res;

  // input register
  logic              in_valid_q;
  logic              mode_q;
  logic [CHAR_W-1:0] char_q;

  logic              out_free;
  logic              step;

  // the output slot is free if empty or being drained this cycle
  assign out_free        = !res_chan_o.valid || res_chan_o.ready;
  assign step            = in_valid_q && out_free;
  assign in_chan_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      in_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.ready && in_chan_i.valid) begin
      mode_q <= in_chan_i.mode;
      char_q <= in_chan_i.char_in;
    end
  end

  lcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_chan_i (cfg_chan_i),
    .cfg_o      (cfg)
  );

  lcc_core #(
    .BUF_LIMIT (BUF_LIMIT),
    .KEY_BYTES (KEY_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .mode_i (mode_q),
    .char_i (char_q),
    .res_o  (res)
  );

  // items that give no result (full buffer, idle tick) leave the output untouched
  lcc_result_reg u_res (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && res.has_res),
    .res_i      (res),
    .res_chan_o (res_chan_o)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench of login_credential_checker: directed and randomised login traffic, self-checked.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  // Generous ceiling: ~1600 items at worst-case gaps and stalls stay well inside it
  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned RANDOM_RESULTS = 840;
  localparam int unsigned RANDOM_PHASES  = 8;

  typedef struct packed {
    event_e            ev;
    logic [CHAR_W-1:0] chr;
  } login_evt_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcc_in_if  in_if ();
  lcc_out_if res_if ();
  lcc_cfg_if cfg_if ();

  login_credential_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .res_chan_o (res_if),
    .cfg_chan_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Login behaviour mirror: configuration copy plus session state
  // ---------------------------------------------------------------------------
  cfg_t              cfg_mirror;
  logic              pw_phase;
  logic [7:0]        user_cnt;
  logic [7:0]        pass_cnt;
  logic              user_ok;
  logic              pass_ok;
  logic              timer_on;
  logic [TICK_W-1:0] tick_cnt;

  login_evt_t  expected_events [$];
  int unsigned result_items;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  bit          src_gaps;
  bit          sink_stalls;

  // Back to an empty username prompt, timer stopped
  function automatic void restart_login();
    pw_phase = 1'b0;
    user_cnt = '0;
    pass_cnt = '0;
    user_ok  = 1'b1;
    pass_ok  = 1'b1;
    timer_on = 1'b0;
    tick_cnt = '0;
  endfunction

  // Positions past the key width never match
  function automatic logic key_byte_ok(input logic [KEY_W-1:0] key, input logic [7:0] pos,
                                       input logic [CHAR_W-1:0] c);
    if (pos >= KEY_BYTES_DEF) return 1'b0;
    return key[8*pos +: 8] == c;
  endfunction

  // Advances the mirror by one item; returns 1 when the item yields a result
  function automatic logic login_step(input logic m, input logic [CHAR_W-1:0] c,
                                      output login_evt_t res);
    res.ev  = EV_ECHO;
    res.chr = '0;
    if (m) begin
      if (!timer_on) return 1'b0;
      // the tick that finds the count already at the limit fires
      if (tick_cnt >= cfg_mirror.timeout_ticks) begin
        restart_login();
        res.ev = EV_TIMEOUT;
        return 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
    end
    if (!pw_phase) begin
      if (c == CHAR_CR) begin
        pw_phase = 1'b1;
        pass_cnt = '0;
        pass_ok  = 1'b1;
        timer_on = 1'b1;
        tick_cnt = '0;
        res.ev   = EV_ASK_PASS;
        return 1'b1;
      end
      if (user_cnt >= BUF_LIMIT_DEF) return 1'b0;
      if (!key_byte_ok(cfg_mirror.user_key, user_cnt, c)) user_ok = 1'b0;
      user_cnt = user_cnt + 1'b1;
      res.chr  = c;
      return 1'b1;
    end
    if (c == CHAR_CR) begin
      res.ev = (user_cnt == cfg_mirror.user_key_len && pass_cnt == cfg_mirror.pass_key_len &&
                user_ok && pass_ok) ? EV_GRANTED : EV_DENIED;
      restart_login();
      return 1'b1;
    end
    if (pass_cnt >= BUF_LIMIT_DEF) return 1'b0;
    if (!key_byte_ok(cfg_mirror.pass_key, pass_cnt, c)) pass_ok = 1'b0;
    pass_cnt = pass_cnt + 1'b1;
    res.chr  = CHAR_STAR;
    return 1'b1;
  endfunction

  // Random key with no carriage return byte, so a whole key can be typed
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < KEY_BYTES_DEF; i++)
      if (k[8*i +: 8] == CHAR_CR) k[8*i +: 8] = k[8*i +: 8] ^ 8'h80;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking.
  // Handshake sampled at the rising edge, i.e. the values in force just before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    login_evt_t exp_evt;
    if (!rst_ni) begin
      stall_left = 0;
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result event %0d char %02h with nothing pending",
                                    res_if.event_res, res_if.char_out));
        end else begin
          exp_evt = expected_events.pop_front();
          if (res_if.event_res !== exp_evt.ev)
            report_mismatch($sformatf("event_res %0d, expected %0d (%s)",
                                      res_if.event_res, exp_evt.ev, exp_evt.ev.name()));
          if (res_if.char_out !== exp_evt.chr)
            report_mismatch($sformatf("char_out %02h, expected %02h on %s",
                                      res_if.char_out, exp_evt.chr, exp_evt.ev.name()));
        end
        // stall drawn afresh after each transfer
        stall_left = sink_stalls ? $urandom_range(0, 9) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** login_credential_checker: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------

  // One item: optional idle gap, then hold valid until the transfer.
  // Valid stays high across back-to-back items (never dropped and raised in one step).
  task automatic send_rx_item(input logic m, input logic [CHAR_W-1:0] c);
    login_evt_t res;
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.char_in <= c;
    if (login_step(m, c, res)) begin
      expected_events.push_back(res);
      result_items++;
    end
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Wait for all results, then let any result-less item still in the pipe retire
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Config valid is kept high through a burst of writes; set_config drops it after
  task automatic write_reg(input cfg_idx_e idx, input logic [KEY_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_USER_KEY:     cfg_mirror.user_key      = val;
      CFG_PASS_KEY:     cfg_mirror.pass_key      = val;
      CFG_USER_KEY_LEN: cfg_mirror.user_key_len  = val[KLEN_W-1:0];
      CFG_PASS_KEY_LEN: cfg_mirror.pass_key_len  = val[KLEN_W-1:0];
      CFG_TIMEOUT:      cfg_mirror.timeout_ticks = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  // Registers are only written with the block idle
  task automatic set_config(input logic [KEY_W-1:0] ukey, input logic [KEY_W-1:0] pkey,
                            input logic [KLEN_W-1:0] ulen, input logic [KLEN_W-1:0] plen,
                            input logic [TICK_W-1:0] tout);
    drain();
    write_reg(CFG_USER_KEY, ukey);
    write_reg(CFG_PASS_KEY, pkey);
    write_reg(CFG_USER_KEY_LEN, ulen);
    write_reg(CFG_PASS_KEY_LEN, plen);
    write_reg(CFG_TIMEOUT, tout);
    cfg_if.valid <= 1'b0;
  endtask

  // Types n characters from a key (random past the key width), one bit flipped at
  // bad_pos if that is a valid position; carriage returns are steered away.
  task automatic type_field(input logic [KEY_W-1:0] key, input int n, input int bad_pos,
                            input bit with_ticks);
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < n; i++) begin
      if (with_ticks && $urandom_range(0, 7) == 0) send_rx_item(1'b1, 8'($urandom));
      ch = 8'($urandom);
      if (i < KEY_BYTES_DEF) ch = key[8*i +: 8];
      if (i == bad_pos) ch = ch ^ (8'h01 << $urandom_range(0, 7));
      if (ch == CHAR_CR) ch = ch ^ 8'h80;
      send_rx_item(1'b0, ch);
    end
  endtask

  task automatic try_login(input logic [KEY_W-1:0] uk, input logic [KEY_W-1:0] pk,
                           input int un, input int pn, input int ub, input int pb);
    type_field(uk, un, ub, 1'b1);
    send_rx_item(1'b0, CHAR_CR);
    type_field(pk, pn, pb, 1'b1);
    send_rx_item(1'b0, CHAR_CR);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: zero keys of length 8, timeout 30
  task automatic test_reset_config();
    type_field('0, 8, -1, 1'b0);
    send_rx_item(1'b0, CHAR_CR);
    type_field('0, 8, -1, 1'b0);
    send_rx_item(1'b0, CHAR_CR);          // granted
    send_rx_item(1'b0, CHAR_CR);          // ask password, timer starts
    repeat (31) send_rx_item(1'b1, 8'($urandom));  // last tick fires
  endtask

  // Every event kind, character extremes, idle tick
  task automatic test_directed();
    set_config(64'h0000_0000_0000_FF00, 64'h0000_0000_0000_00FF, 4'd2, 4'd1, 6'd1);
    send_rx_item(1'b1, 8'hFF);            // tick, timer idle: nothing
    send_rx_item(1'b0, 8'h00);
    send_rx_item(1'b0, 8'hFF);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b1, 8'h00);            // tick count 0 -> 1
    send_rx_item(1'b0, 8'hFF);            // echoed as star
    send_rx_item(1'b0, CHAR_CR);          // granted
    send_rx_item(1'b0, 8'h80);            // wrong first character
    send_rx_item(1'b0, 8'h7F);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b0, CHAR_CR);          // denied, no password typed
    send_rx_item(1'b0, CHAR_CR);          // ask, empty username
    send_rx_item(1'b1, 8'h55);
    send_rx_item(1'b1, 8'hAA);            // timed out
    send_rx_item(1'b1, 8'h01);            // timer stopped again
    send_rx_item(1'b0, 8'h01);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b0, 8'hFE);
    send_rx_item(1'b0, CHAR_CR);          // denied, username and password mismatch
  endtask

  // Empty keys and a zero timeout: first tick fires
  task automatic test_empty_keys();
    logic [KEY_W-1:0] uk;
    uk = rand_key();
    set_config(uk, rand_key(), 4'd0, 4'd0, 6'd0);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b1, 8'h3C);            // timed out at once
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b0, CHAR_CR);          // granted with empty fields
    send_rx_item(1'b0, uk[7:0] ^ 8'h01);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b0, CHAR_CR);          // denied on length
  endtask

  // Key lengths beyond the key width can never be granted
  task automatic test_long_keys();
    logic [KEY_W-1:0] uk;
    logic [KEY_W-1:0] pk;
    uk = rand_key();
    pk = rand_key();
    set_config(uk, pk, 4'd9, 4'd15, 6'd63);
    try_login(uk, pk, 9, 15, -1, -1);
    try_login(uk, pk, 8, 8, -1, -1);
  endtask

  // Both buffers filled past the limit; extra characters are dropped silently
  task automatic test_buffer_full();
    logic [KEY_W-1:0] uk;
    logic [KEY_W-1:0] pk;
    uk = rand_key();
    pk = rand_key();
    set_config(uk, pk, 4'd8, 4'd8, 6'd63);
    type_field(uk, BUF_LIMIT_DEF + 2, -1, 1'b0);
    send_rx_item(1'b0, CHAR_CR);
    type_field(pk, BUF_LIMIT_DEF + 2, -1, 1'b0);
    send_rx_item(1'b0, CHAR_CR);
  endtask

  // Largest timeout and a timeout of 1; count restarts from zero on every new password prompt
  task automatic test_timeout_limits();
    logic [KEY_W-1:0] uk;
    logic [KEY_W-1:0] pk;
    uk = rand_key();
    pk = rand_key();
    set_config(uk, pk, 4'd1, 4'd1, 6'd63);
    send_rx_item(1'b0, uk[7:0]);
    send_rx_item(1'b0, CHAR_CR);
    repeat (63) send_rx_item(1'b1, 8'($urandom));
    send_rx_item(1'b0, pk[7:0]);
    send_rx_item(1'b1, 8'($urandom));     // fires on the tick after the limit
    send_rx_item(1'b0, CHAR_CR);
    repeat (40) send_rx_item(1'b1, 8'($urandom));
    send_rx_item(1'b0, CHAR_CR);          // denied, timer stops
    send_rx_item(1'b0, CHAR_CR);          // fresh prompt, count cleared
    repeat (63) send_rx_item(1'b1, 8'($urandom));
    send_rx_item(1'b1, 8'($urandom));
    set_config(uk, pk, 4'd1, 4'd1, 6'd1);
    send_rx_item(1'b0, CHAR_CR);
    send_rx_item(1'b1, 8'($urandom));
    send_rx_item(1'b1, 8'($urandom));
  endtask

  // One randomised session: mostly well-formed logins, some broken ones and noise
  task automatic login_session();
    int unsigned kind;
    int          ul;
    int          pl;
    int          ub;
    int          pb;
    logic [KEY_W-1:0] uk;
    logic [KEY_W-1:0] pk;
    kind = $urandom_range(0, 9);
    uk   = cfg_mirror.user_key;
    pk   = cfg_mirror.pass_key;
    ul   = cfg_mirror.user_key_len;
    pl   = cfg_mirror.pass_key_len;
    ub   = -1;
    pb   = -1;
    case (kind)
      0, 1, 2, 3: try_login(uk, pk, ul, pl, -1, -1);
      4: begin
        // one wrong character
        if ($urandom_range(0, 1) == 0 && ul != 0) ub = $urandom_range(0, (ul > 8 ? 8 : ul) - 1);
        else if (pl != 0) pb = $urandom_range(0, (pl > 8 ? 8 : pl) - 1);
        try_login(uk, pk, ul, pl, ub, pb);
      end
      5: begin
        // one length off by one
        if ($urandom_range(0, 1) == 0) ul = (ul == 0 || $urandom_range(0, 1) == 0) ? ul + 1 : ul - 1;
        else pl = (pl == 0 || $urandom_range(0, 1) == 0) ? pl + 1 : pl - 1;
        try_login(uk, pk, ul, pl, -1, -1);
      end
      6: try_login(rand_key(), rand_key(), $urandom_range(0, 12), $urandom_range(0, 12), -1, -1);
      7: begin
        // run the timer out, or nearly
        type_field(uk, ul, -1, 1'b0);
        send_rx_item(1'b0, CHAR_CR);
        repeat ($urandom_range(0, cfg_mirror.timeout_ticks + 2)) send_rx_item(1'b1, 8'($urandom));
        if ($urandom_range(0, 1) == 0) send_rx_item(1'b0, CHAR_CR);
      end
      8: begin
        // noise, may leave the block mid-session
        repeat ($urandom_range(1, 12))
          send_rx_item($urandom_range(0, 1),
                       ($urandom_range(0, 3) == 0) ? CHAR_CR : 8'($urandom));
      end
      default: begin
        if ($urandom_range(0, 3) == 0)
          try_login(uk, pk, $urandom_range(BUF_LIMIT_DEF - 8, BUF_LIMIT_DEF + 7),
                    $urandom_range(0, 1) ? pl : $urandom_range(BUF_LIMIT_DEF - 8, BUF_LIMIT_DEF + 7),
                    -1, -1);
        else
          try_login(uk, pk, ul, pl, -1, -1);
      end
    endcase
  endtask

  // Several configurations, extremes first, each with its own idle pattern
  task automatic test_random();
    int unsigned goal;
    int unsigned ul;
    int unsigned pl;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config('1, '1, 4'd8, 4'd8, 6'd63);
        1: set_config('0, '0, 4'd0, 4'd0, 6'd1);
        default: begin
          ul = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          pl = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          set_config(rand_key(), rand_key(), KLEN_W'(ul), KLEN_W'(pl),
                     TICK_W'($urandom_range(0, 63)));
        end
      endcase
      src_gaps    = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      goal = result_items + RANDOM_RESULTS / RANDOM_PHASES;
      while (result_items < goal) login_session();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = 1'b0;
    in_if.char_in  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_USER_KEY;
    cfg_if.data    = '0;
    src_gaps       = 1'b1;
    sink_stalls    = 1'b1;
    result_items   = 0;
    cfg_mirror = '{user_key: USER_KEY_RST, pass_key: PASS_KEY_RST,
                   user_key_len: USER_KEY_LEN_RST, pass_key_len: PASS_KEY_LEN_RST,
                   timeout_ticks: TIMEOUT_RST};
    restart_login();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_directed();
    test_empty_keys();
    test_long_keys();
    test_buffer_full();
    test_timeout_limits();
    test_random();

    drain();
    if (mismatches == 0) begin
      $display("** login_credential_checker: PASSED **");
    end else begin
      $display("** login_credential_checker: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/lcc_pkg.sv
hdl/lcc_if.sv
hdl/lcc_cfg_regs.sv
hdl/lcc_core.sv
hdl/lcc_result_reg.sv
hdl/login_credential_checker.sv
dv/tb.sv
